@@ rtl/mf_pkg.sv @@
// Shared constants, types and codes for the 3x3 median filter.
// Used by every module of the block except mf_ram; depends on nothing else.
package mf_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int PIXEL_BITS = 8;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS = COL_BITS + 1;
  localparam int HEIGHT_BITS = 13;
  localparam int ROW_BITS = HEIGHT_BITS + 1;
  localparam int WIDTH_REG_BITS = 11;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 13;

  localparam int RESET_WIDTH = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int RESET_EFF_WIDTH = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  localparam int TAPS = 9;
  localparam int TAP_BITS = $clog2(TAPS);

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_PTR_BITS = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_COUNT_BITS = JOBQ_PTR_BITS + 1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef pixel_t [TAPS-1:0] taps_t;

  typedef struct packed {
    taps_t taps;
    logic  last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

  typedef struct packed {
    logic                       empty;
    logic [JOBQ_COUNT_BITS-1:0] count;
  } jobq_status_t;

endpackage

@@ rtl/mf_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// A read at the address being written returns the old data. No dependencies.
module mf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mf_front.sv @@
// Front end: configuration, input classification, line buffers, 3x3 window and
// edge replication. Emits one job of nine taps per output pixel. Uses mf_pkg, mf_ram.
module mf_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic                              cmd,
  input  logic [mf_pkg::PIXEL_BITS-1:0]     pixel,
  input  mf_pkg::jobq_status_t              q_status,
  output mf_pkg::job_push_t                 q_push
);
  import mf_pkg::*;

  localparam int FLIGHT_BITS = JOBQ_COUNT_BITS + 1;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } edge_t;

  logic [WIDTH_BITS-1:0]  w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;
  logic [WIDTH_BITS-1:0]  cfg_w_eff;
  logic [HEIGHT_BITS-1:0] cfg_h_eff;
  logic                   cfg_write;
  logic                   cfg_restart;

  logic [COL_BITS-1:0]    in_column, in_column_next;
  logic [ROW_BITS-1:0]    in_row, in_row_next;
  logic [COL_BITS-1:0]    out_column, out_column_next;
  logic [HEIGHT_BITS-1:0] out_row, out_row_next;

  logic  accept, take, complete, emit, col_wrap;
  edge_t edges;

  logic                   s1_valid, s1_emit;
  logic [COL_BITS-1:0]    s1_column;
  pixel_t                 s1_pixel, s1_above, s1_mid;
  edge_t                  s1_edges;
  logic                   byp_hit;
  logic [2*PIXEL_BITS-1:0] byp_word, ram_word, s1_word;

  taps_t                  window;
  logic                   s2_emit;
  edge_t                  s2_edges;
  taps_t                  job_taps;
  logic [FLIGHT_BITS-1:0] in_flight;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_write &&
                       (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_comb begin
    if (cfg_data[WIDTH_REG_BITS-1:0] == '0) begin
      cfg_w_eff = WIDTH_BITS'(1);
    end else if (32'(cfg_data[WIDTH_REG_BITS-1:0]) > 32'(MAX_WIDTH)) begin
      cfg_w_eff = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      cfg_w_eff = WIDTH_BITS'(cfg_data[WIDTH_REG_BITS-1:0]);
    end
    if (cfg_data[HEIGHT_BITS-1:0] == '0) begin
      cfg_h_eff = HEIGHT_BITS'(1);
    end else begin
      cfg_h_eff = cfg_data[HEIGHT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= WIDTH_BITS'(RESET_EFF_WIDTH);
      h_eff <= HEIGHT_BITS'(RESET_HEIGHT);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: w_eff <= cfg_w_eff;
        REG_IMAGE_HEIGHT: h_eff <= cfg_h_eff;
        default: ;
      endcase
    end
  end

  assign in_flight = FLIGHT_BITS'(q_status.count) + FLIGHT_BITS'(s1_emit) +
                     FLIGHT_BITS'(s2_emit);
  assign full = rst || (in_flight >= FLIGHT_BITS'(JOBQ_DEPTH));
  assign accept = push && !full;
  assign complete = in_row >= ROW_BITS'(h_eff);
  assign take = accept && ((cmd == CMD_DRAIN) == complete);
  assign emit = (in_row >= ROW_BITS'(2)) || (in_row == ROW_BITS'(1) && in_column != '0);
  assign col_wrap = (WIDTH_BITS'(in_column) + WIDTH_BITS'(1)) == w_eff;

  assign edges.top = out_row == '0;
  assign edges.bottom = out_row == (h_eff - HEIGHT_BITS'(1));
  assign edges.left = out_column == '0;
  assign edges.right = WIDTH_BITS'(out_column) == (w_eff - WIDTH_BITS'(1));
  assign edges.last = edges.bottom && edges.right;

  always_comb begin
    in_column_next = in_column;
    in_row_next = in_row;
    out_column_next = out_column;
    out_row_next = out_row;
    if (take) begin
      if (col_wrap) begin
        in_column_next = '0;
        in_row_next = in_row + ROW_BITS'(1);
      end else begin
        in_column_next = in_column + COL_BITS'(1);
      end
      if (emit) begin
        if (edges.right) begin
          out_column_next = '0;
          out_row_next = out_row + HEIGHT_BITS'(1);
        end else begin
          out_column_next = out_column + COL_BITS'(1);
        end
        if (edges.last) begin
          in_column_next = '0;
          in_row_next = '0;
          out_column_next = '0;
          out_row_next = '0;
        end
      end
    end
    if (cfg_restart) begin
      in_column_next = '0;
      in_row_next = '0;
      out_column_next = '0;
      out_row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row <= '0;
      out_column <= '0;
      out_row <= '0;
      s1_valid <= 1'b0;
      s1_emit <= 1'b0;
      byp_hit <= 1'b0;
      s2_emit <= 1'b0;
    end else begin
      in_column <= in_column_next;
      in_row <= in_row_next;
      out_column <= out_column_next;
      out_row <= out_row_next;
      s1_valid <= take;
      s1_emit <= take && emit;
      byp_hit <= take && s1_valid && (s1_column == in_column);
      s2_emit <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_column <= in_column;
      s1_pixel <= (cmd == CMD_DRAIN) ? '0 : pixel;
      s1_edges <= edges;
    end
    byp_word <= {s1_mid, s1_pixel};
    s2_edges <= s1_edges;
  end

  mf_ram #(
    .WIDTH(2 * PIXEL_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_column),
    .wdata({s1_mid, s1_pixel}),
    .re   (take),
    .raddr(in_column),
    .rdata(ram_word)
  );

  assign s1_word = byp_hit ? byp_word : ram_word;
  assign s1_above = s1_word[2*PIXEL_BITS-1:PIXEL_BITS];
  assign s1_mid = s1_word[PIXEL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        window[3*r] <= window[3*r+1];
        window[3*r+1] <= window[3*r+2];
      end
      window[2] <= s1_above;
      window[5] <= s1_mid;
      window[8] <= s1_pixel;
    end
  end

  always_comb begin
    logic [1:0]          sr;
    logic [1:0]          sc;
    logic [TAP_BITS-1:0] idx;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sr = 2'(r);
        sc = 2'(c);
        if ((r == 0 && s2_edges.top) || (r == 2 && s2_edges.bottom)) begin
          sr = 2'd1;
        end
        if ((c == 0 && s2_edges.left) || (c == 2 && s2_edges.right)) begin
          sc = 2'd1;
        end
        idx = TAP_BITS'(3 * sr + sc);
        job_taps[3*r+c] = window[idx];
      end
    end
  end

  assign q_push.valid = s2_emit;
  assign q_push.job.taps = job_taps;
  assign q_push.job.last = s2_edges.last;

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    in_flight <= FLIGHT_BITS'(JOBQ_DEPTH))
    else $error("Job queue space overcommitted.");

  a_column_range: assert property (@(posedge clk) disable iff (rst)
    WIDTH_BITS'(in_column) < w_eff)
    else $error("Input column outside the line.");

  a_last_restart: assert property (@(posedge clk) disable iff (rst)
    take && emit && edges.last |=>
      (in_row == '0 && in_column == '0 && out_row == '0 && out_column == '0))
    else $error("Image position not cleared after the last word.");

endmodule

@@ rtl/mf_jobq.sv @@
// Short job queue between the window front end and the median back end.
// Holds complete neighborhoods so each side can stall on its own. Uses mf_pkg.
module mf_jobq (
  input  logic                 clk,
  input  logic                 rst,
  input  mf_pkg::job_push_t    q_push,
  input  logic                 q_pop,
  output mf_pkg::job_t         q_head,
  output mf_pkg::jobq_status_t q_status
);
  import mf_pkg::*;

  job_t                       entries [JOBQ_DEPTH];
  logic [JOBQ_PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [JOBQ_COUNT_BITS-1:0] count;

  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      entries[wr_ptr] <= q_push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (q_push.valid) begin
        wr_ptr <= wr_ptr + JOBQ_PTR_BITS'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + JOBQ_PTR_BITS'(1);
      end
      case ({q_push.valid, q_pop})
        2'b10: count <= count + JOBQ_COUNT_BITS'(1);
        2'b01: count <= count - JOBQ_COUNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

  assign q_head = entries[rd_ptr];
  assign q_status.count = count;
  assign q_status.empty = count == '0;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != '0)
    else $error("Job queue read while empty.");

endmodule

@@ rtl/mf_median.sv @@
// Back end: three-stage median-of-nine sorting network and the result register.
// Pulls jobs from the job queue and presents one result word. Uses mf_pkg.
module mf_median (
  input  logic                          clk,
  input  logic                          rst,
  input  mf_pkg::job_t                  q_head,
  input  mf_pkg::jobq_status_t          q_status,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [mf_pkg::PIXEL_BITS-1:0] median,
  output logic                          last
);
  import mf_pkg::*;

  function automatic taps_t cx(input taps_t v, input int i, input int j);
    taps_t r;
    r = v;
    if (v[i] > v[j]) begin
      r[i] = v[j];
      r[j] = v[i];
    end
    return r;
  endfunction

  logic   v1, v2, v3;
  logic   rdy1, rdy2, rdy3;
  taps_t  s1_taps, s2_taps, s1_taps_next, s2_taps_next;
  logic   s1_last, s2_last;
  pixel_t median_next;

  assign rdy3 = !v3 || pop;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign q_pop = !q_status.empty && rdy1;

  always_comb begin
    taps_t a;
    a = q_head.taps;
    a = cx(a, 1, 2);
    a = cx(a, 4, 5);
    a = cx(a, 7, 8);
    a = cx(a, 0, 1);
    a = cx(a, 3, 4);
    a = cx(a, 6, 7);
    a = cx(a, 1, 2);
    a = cx(a, 4, 5);
    a = cx(a, 7, 8);
    s1_taps_next = a;
  end

  always_comb begin
    taps_t b;
    b = s1_taps;
    b = cx(b, 0, 3);
    b = cx(b, 5, 8);
    b = cx(b, 4, 7);
    b = cx(b, 3, 6);
    b = cx(b, 1, 4);
    b = cx(b, 2, 5);
    b = cx(b, 4, 7);
    s2_taps_next = b;
  end

  always_comb begin
    taps_t d;
    d = s2_taps;
    d = cx(d, 4, 2);
    d = cx(d, 6, 4);
    d = cx(d, 4, 2);
    median_next = d[4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= q_pop;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_taps <= s1_taps_next;
      s1_last <= q_head.last;
    end
    if (rdy2 && v1) begin
      s2_taps <= s2_taps_next;
      s2_last <= s1_last;
    end
    if (rdy3 && v2) begin
      median <= median_next;
      last <= s2_last;
    end
  end

  assign empty = !v3;

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> v1)
    else $error("Job taken from the queue was not loaded.");

endmodule

@@ rtl/median_filter_3x3_top.sv @@
// Top level of the 3x3 median filter for raster streams of gray pixels.
// Uses mf_pkg and instantiates mf_front, mf_jobq and mf_median.
//
// Input queue: a word (cmd, pixel) is taken at a rising edge with push high
// and full low. Pixel words come in raster order; once the image is complete,
// drain words (cmd high) flush the width + 1 pending results. Words that do
// not fit the current phase are taken and dropped without a result.
// Result queue: while empty is low, median and last show the oldest result;
// pop high at a rising edge takes it. last marks the final pixel of the image.
// Configuration: cfg_index selects image width (0) or image height (1);
// cfg_ready is always high, and any such write restarts the image.
// Throughput is one word per cycle while full is low. A result passes from the
// word that releases it through the line RAM read, the window register, the job
// queue and the three-stage sorting network, whose first stage loads straight
// from the queue head.
// The first result of an image is released by the pixel one line plus one
// pixel after it. If pop stays low, the sorting stages, the result register and
// a four-entry job queue fill, and full rises only when the queue cannot take
// what is in flight.
// Reset clears positions and queues and loads width 640 and height 480; the
// line RAM is not cleared, as unwritten entries only feed replicated edges.
module median_filter_3x3_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic                              cmd,
  input  logic [mf_pkg::PIXEL_BITS-1:0]     pixel,
  output logic                              empty,
  input  logic                              pop,
  output logic [mf_pkg::PIXEL_BITS-1:0]     median,
  output logic                              last
);
  import mf_pkg::*;

  job_push_t    q_push;
  job_t         q_head;
  jobq_status_t q_status;
  logic         q_pop;

  mf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .cmd      (cmd),
    .pixel    (pixel),
    .q_status (q_status),
    .q_push   (q_push)
  );

  mf_jobq u_jobq (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_status(q_status)
  );

  mf_median u_median (
    .clk     (clk),
    .rst     (rst),
    .q_head  (q_head),
    .q_status(q_status),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .median  (median),
    .last    (last)
  );

endmodule
